[rtl/kls_pkg.sv]
// Shared types, constants and character helpers for the keyword lexical scanner.
// Used by kls_core, keyword_lexical_scanner_unit and kls_checker; no dependencies.
package kls_pkg;

  localparam int MAX_TEXT_DEF = 15;
  localparam int TEXT_BYTES   = 16;
  localparam int TEXT_W       = 8 * TEXT_BYTES;
  localparam int LEN_MAX      = 15;
  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_W        = 2;
  localparam int CNT_W        = 3;

  // token classes of the pending token
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_NAME = 2'd1;
  localparam logic [1:0] CLS_NUM  = 2'd2;
  localparam logic [1:0] CLS_OP   = 2'd3;

  // token codes
  localparam logic [7:0] CODE_NAME  = 8'h78;  // x
  localparam logic [7:0] CODE_IF    = 8'h69;  // i
  localparam logic [7:0] CODE_ELSE  = 8'h6C;  // l
  localparam logic [7:0] CODE_END   = 8'h65;  // e
  localparam logic [7:0] CODE_NUM   = 8'h23;  // #
  localparam logic [7:0] CODE_OTHER = 8'h3F;  // ?

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // keywords as zero-padded text, first character in the low byte
  localparam logic [TEXT_W-1:0] KW_IF    = TEXT_W'(32'h0000_4649);
  localparam logic [TEXT_W-1:0] KW_ELSE  = TEXT_W'(32'h4553_4C45);
  localparam logic [TEXT_W-1:0] KW_ENDIF = TEXT_W'(40'h46_4944_4E45);
  localparam logic [TEXT_W-1:0] KW_END   = TEXT_W'(32'h0044_4E45);

  typedef struct packed {
    logic [7:0]        code;
    logic [3:0]        len;
    logic [TEXT_W-1:0] text;
    logic              ovf;
    logic              last;
  } kls_tok_t;

  // results produced by one character: count, then in order
  typedef struct packed {
    logic [1:0] n;
    kls_tok_t   res0;
    kls_tok_t   res1;
  } kls_push_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
           c == 8'h3C || c == 8'h3E || c == 8'h3A || c == 8'h3D;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  // build a result from a pending token; text is already masked past its length
  function automatic kls_tok_t tok_make(input logic [1:0] cls, input logic [TEXT_W-1:0] text,
                                        input logic [3:0] len, input logic ovf);
    kls_tok_t t;
    t.text = text;
    t.len  = len;
    t.ovf  = ovf;
    t.last = 1'b0;
    unique case (cls)
      CLS_NAME: begin
        if (ovf)                  t.code = CODE_NAME;
        else if (text == KW_IF)    t.code = CODE_IF;
        else if (text == KW_ELSE)  t.code = CODE_ELSE;
        else if (text == KW_ENDIF) t.code = CODE_END;
        else if (text == KW_END)   t.code = CODE_END;
        else                       t.code = CODE_NAME;
      end
      CLS_NUM: t.code = CODE_NUM;
      CLS_OP:  t.code = (len == 4'd1 && !ovf) ? text[7:0] : CODE_OTHER;
      default: t.code = CODE_OTHER;
    endcase
    return t;
  endfunction

endpackage

[rtl/kls_core.sv]
// Scanner state (class, kept text, count, overflow) and per-character result forming.
// Depends on kls_pkg.
module kls_core #(
  parameter int MAX_TEXT = kls_pkg::MAX_TEXT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ch,
  input  logic              eoi,
  output kls_pkg::kls_push_t push
);
  import kls_pkg::*;

  localparam int CW = $clog2(MAX_TEXT + 1);

  logic [1:0]    cls_r, cls_nxt, cls_mid, cls_new;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_mid, pos;
  logic          ovf_r, ovf_nxt, ovf_mid;
  logic [7:0]    store_r   [MAX_TEXT];
  logic [7:0]    store_mid [MAX_TEXT];

  logic          letter, digit, op, sep, other, cont, start, keep, can_keep;
  logic          va, vb, vc;
  logic [7:0]    kept;
  logic [TEXT_W-1:0] text_old, text_mid;
  kls_tok_t      ra, rb, rc;

  function automatic logic [3:0] len_of(input logic [CW-1:0] c);
    return (c > CW'(LEN_MAX)) ? 4'(LEN_MAX) : 4'(c);
  endfunction

  always_comb begin
    letter = is_letter(ch);
    digit  = is_digit(ch);
    op     = is_op(ch);
    sep    = is_sep(ch);
    other  = !(letter || digit || op || sep);
    cont   = (cls_r == CLS_NAME && (letter || digit)) ||
             (cls_r == CLS_NUM && digit) ||
             (cls_r == CLS_OP && op);
    start  = !cont && (letter || digit || op);
    keep   = cont || start;
    kept   = to_upper(ch);
    pos    = cont ? cnt_r : '0;
    can_keep = pos < CW'(MAX_TEXT);

    priority if (letter) cls_new = CLS_NAME;
    else if (digit)      cls_new = CLS_NUM;
    else                 cls_new = CLS_OP;

    // state after this character, before any end-of-input flush
    cls_mid = cont ? cls_r : (start ? cls_new : CLS_NONE);
    cnt_mid = (keep && can_keep) ? pos + CW'(1) : (cont ? cnt_r : '0);
    ovf_mid = cont ? (ovf_r || !can_keep) : 1'b0;
    for (int i = 0; i < MAX_TEXT; i++) begin
      store_mid[i] = (keep && can_keep && pos == CW'(i)) ? kept : store_r[i];
    end

    text_old = '0;
    text_mid = '0;
    for (int i = 0; i < MAX_TEXT; i++) begin
      if (CW'(i) < cnt_r)   text_old[i*8 +: 8] = store_r[i];
      if (CW'(i) < cnt_mid) text_mid[i*8 +: 8] = store_mid[i];
    end

    ra = tok_make(cls_r, text_old, len_of(cnt_r), ovf_r);
    rb.code = CODE_OTHER;
    rb.len  = 4'd1;
    rb.text = TEXT_W'(ch);
    rb.ovf  = 1'b0;
    rb.last = 1'b0;
    rc = tok_make(cls_mid, text_mid, len_of(cnt_mid), ovf_mid);

    va = !cont && cls_r != CLS_NONE;
    vb = other;
    vc = eoi && cls_mid != CLS_NONE;

    // order: pending flush, then the lone token or the end-of-input flush
    push.res0 = va ? ra : (vb ? rb : rc);
    push.res1 = vb ? rb : rc;
    push.n    = 2'(va) + 2'(vb || vc);
    push.res0.last = (push.n == 2'd1);
    push.res1.last = 1'b1;

    cls_nxt = eoi ? CLS_NONE : cls_mid;
    cnt_nxt = eoi ? '0 : cnt_mid;
    ovf_nxt = eoi ? 1'b0 : ovf_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= CLS_NONE;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (step) begin
      cls_r <= cls_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < MAX_TEXT; i++) store_r[i] <= store_mid[i];
    end
  end

endmodule

[rtl/keyword_lexical_scanner_unit.sv]
// Keyword lexical scanner top level: input register, kls_core, result queue.
// Depends on kls_pkg and kls_core.
//
// Usage: one ASCII character per input request (in_char_in, plus in_end_of_input to
// flush the pending token after that character). Each accepted character yields zero,
// one or two token results on the out_ channel; out_last_of_run marks the final result
// a character caused. Results keep character order.
// Path: a character waits in the input register, which steps its results into the
// result queue once the queue has room for two results; the queue head drives out_.
// Throughput: one character per cycle, sustained while the output side takes one
// result per cycle; a character that yields two results puts both on the output in
// turn, and the four-entry result queue absorbs such bursts. The input register
// advances only when the queue has room for two results, so that sets when in_ready
// drops.
// Stall: when out_ready is low the queue holds its head steady; once it has room
// for fewer than two results, the input register holds and in_ready falls. Nothing is dropped.
// Reset (rst_n low, synchronous): clear the pending token, empty the input register
// and the queue. Kept text needs no clearing: only written bytes are ever shown.
module keyword_lexical_scanner_unit #(
  parameter int MAX_TEXT = kls_pkg::MAX_TEXT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_token_code,
  output logic [3:0]  out_token_length,
  output logic [63:0] out_text_low,
  output logic [63:0] out_text_high,
  output logic        out_text_overflow,
  output logic        out_last_of_run
);
  import kls_pkg::*;

  // input register
  logic       ir_valid_r, ir_valid_nxt;
  logic [7:0] ir_char_r;
  logic       ir_eoi_r;
  logic       fire;

  // result queue
  kls_tok_t         fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  kls_push_t        push;
  kls_tok_t         head_tok;

  // advance the input register only with room for two results
  assign fire     = ir_valid_r && (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_ready = !ir_valid_r || fire;

  always_comb begin
    ir_valid_nxt = ir_valid_r;
    if (fire)     ir_valid_nxt = 1'b0;
    if (in_valid && in_ready) ir_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ir_valid_r <= 1'b0;
    else        ir_valid_r <= ir_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_char_r <= in_char_in;
      ir_eoi_r  <= in_end_of_input;
    end
  end

  kls_core #(.MAX_TEXT(MAX_TEXT)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .ch    (ir_char_r),
    .eoi   (ir_eoi_r),
    .push  (push)
  );

  // queue bookkeeping: push up to two results, pop one
  always_comb begin
    pop      = out_valid && out_ready;
    head_nxt = pop ? head_r + PTR_W'(1) : head_r;
    tail_nxt = fire ? tail_r + PTR_W'(push.n) : tail_r;
    cnt_nxt  = cnt_r + (fire ? CNT_W'(push.n) : '0) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && push.n != 2'd0) fifo_r[tail_r] <= push.res0;
    if (fire && push.n == 2'd2) fifo_r[tail_r + PTR_W'(1)] <= push.res1;
  end

  assign head_tok          = fifo_r[head_r];
  assign out_valid         = cnt_r != '0;
  assign out_token_code    = head_tok.code;
  assign out_token_length  = head_tok.len;
  assign out_text_low      = head_tok.text[63:0];
  assign out_text_high     = head_tok.text[127:64];
  assign out_text_overflow = head_tok.ovf;
  assign out_last_of_run   = head_tok.last;

endmodule

[rtl/kls_checker.sv]
// Port-level checks for keyword_lexical_scanner_unit, attached by bind.
// Depends on kls_pkg.
module kls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_token_code,
  input logic [3:0]  out_token_length,
  input logic [63:0] out_text_low,
  input logic [63:0] out_text_high,
  input logic        out_text_overflow,
  input logic        out_last_of_run
);
  import kls_pkg::*;

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_code) &&
      $stable(out_token_length) && $stable(out_text_low) && $stable(out_text_high) &&
      $stable(out_text_overflow) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // every token keeps at least one character
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_length != 4'd0)
    else $error("empty token");

  // a keyword IF is exactly the two kept characters, never overflowed
  a_if_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_code == CODE_IF |->
      out_token_length == 4'd2 && !out_text_overflow && out_text_low[15:0] == 16'h4649)
    else $error("bad IF token");

  // a number token starts with a digit
  a_num_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_code == CODE_NUM |->
      out_text_low[7:0] >= 8'h30 && out_text_low[7:0] <= 8'h39)
    else $error("number token without leading digit");

endmodule

bind keyword_lexical_scanner_unit kls_checker u_kls_checker (.*);

[bench/keyword_lexical_scanner_unit_test.sv]
// Self-checking bench for keyword_lexical_scanner_unit: character requests in, token results out.
// Depends on kls_pkg and the scanner RTL; a token predictor class keeps the expected tokens.
`timescale 1ns / 100ps

module keyword_lexical_scanner_unit_test;
  import kls_pkg::*;

  localparam int    MAX_KEPT    = MAX_TEXT_DEF;
  localparam int    RUN_LIMIT   = 200000;
  localparam int    LONG_HOLD   = 48;
  localparam int    PHASE_ITEMS = 170;
  localparam string OP_CHARS    = "+-*/<>:=";

  typedef struct {
    logic [7:0]  code;
    logic [3:0]  len;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        ovf;
    logic        last;
  } token_t;

  // Tracks the pending token the scanner should hold and queues the tokens it owes.
  class token_predictor;
    logic [1:0] cls;
    logic [7:0] kept_text [16];
    int         kept;
    bit         dropped;
    token_t     due_tokens [$];
    int         mismatches;

    function new();
      cls        = CLS_NONE;
      kept       = 0;
      dropped    = 1'b0;
      mismatches = 0;
    endfunction

    function bit letter_ch(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit oper_ch(logic [7:0] c);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < OP_CHARS.len(); i++)
        if (c == OP_CHARS[i]) hit = 1'b1;
      return hit;
    endfunction

    function bit blank_ch(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NL;
    endfunction

    function logic [7:0] upcase(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'h20 : c;
    endfunction

    function void keep(logic [7:0] c);
      if (kept < MAX_KEPT && kept < 16) begin
        kept_text[kept] = c;
        kept++;
      end else begin
        dropped = 1'b1;
      end
    endfunction

    function token_t make_token(logic [7:0] code);
      token_t t;
      t.code = code;
      t.lo   = '0;
      t.hi   = '0;
      for (int i = 0; i < kept && i < 16; i++) begin
        if (i < 8) t.lo[8*i +: 8] = kept_text[i];
        else       t.hi[8*(i-8) +: 8] = kept_text[i];
      end
      t.len  = (kept > 15) ? 4'd15 : 4'(kept);
      t.ovf  = dropped;
      t.last = 1'b0;
      return t;
    endfunction

    function logic [7:0] name_code();
      token_t       t;
      logic [127:0] txt;
      t   = make_token(CODE_NAME);
      txt = {t.hi, t.lo};
      if (dropped)          return CODE_NAME;
      if (txt == KW_IF)     return CODE_IF;
      if (txt == KW_ELSE)   return CODE_ELSE;
      if (txt == KW_ENDIF)  return CODE_END;
      if (txt == KW_END)    return CODE_END;
      return CODE_NAME;
    endfunction

    function void flush_pending();
      logic [7:0] code;
      if (cls == CLS_NONE) return;
      case (cls)
        CLS_NAME: code = name_code();
        CLS_NUM:  code = CODE_NUM;
        default:  code = (kept == 1 && !dropped) ? kept_text[0] : CODE_OTHER;
      endcase
      due_tokens.push_back(make_token(code));
      cls     = CLS_NONE;
      kept    = 0;
      dropped = 1'b0;
    endfunction

    // Note one accepted character request and queue the tokens it releases.
    function void take_char(logic [7:0] c, logic eoi);
      int due_at_entry;
      bit cont;
      due_at_entry = due_tokens.size();
      cont = (cls == CLS_NAME && (letter_ch(c) || digit_ch(c))) ||
             (cls == CLS_NUM && digit_ch(c)) ||
             (cls == CLS_OP && oper_ch(c));
      if (cont) begin
        keep(cls == CLS_NAME ? upcase(c) : c);
      end else begin
        flush_pending();
        if (letter_ch(c)) begin
          cls = CLS_NAME;
          keep(upcase(c));
        end else if (digit_ch(c)) begin
          cls = CLS_NUM;
          keep(c);
        end else if (oper_ch(c)) begin
          cls = CLS_OP;
          keep(c);
        end else if (!blank_ch(c)) begin
          // stray character: a one-byte token of its own
          kept_text[0] = c;
          kept         = 1;
          dropped      = 1'b0;
          due_tokens.push_back(make_token(CODE_OTHER));
          kept         = 0;
        end
      end
      if (eoi) flush_pending();
      if (due_tokens.size() > due_at_entry) due_tokens[due_tokens.size()-1].last = 1'b1;
    endfunction

    task log_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compare one accepted result against the oldest queued token.
    task match_token(logic [7:0] code, logic [3:0] len, logic [63:0] lo, logic [63:0] hi,
                     logic ovf, logic last);
      token_t want;
      if (due_tokens.size() == 0) begin
        log_mismatch($sformatf("token code %h arrived with nothing due", code));
        return;
      end
      want = due_tokens.pop_front();
      if (code !== want.code) log_mismatch($sformatf("code %h, want %h", code, want.code));
      if (len !== want.len)   log_mismatch($sformatf("length %0d, want %0d", len, want.len));
      if (lo !== want.lo)     log_mismatch($sformatf("text_low %h, want %h", lo, want.lo));
      if (hi !== want.hi)     log_mismatch($sformatf("text_high %h, want %h", hi, want.hi));
      if (ovf !== want.ovf)   log_mismatch($sformatf("overflow %b, want %b", ovf, want.ovf));
      if (last !== want.last) log_mismatch($sformatf("last %b, want %b", last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_in;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_token_code;
  logic [3:0]  out_token_length;
  logic [63:0] out_text_low;
  logic [63:0] out_text_high;
  logic        out_text_overflow;
  logic        out_last_of_run;

  token_predictor chars = new();

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int hold_left;
  bit hold_req;
  int cycles;

  always #10 clk = ~clk;

  keyword_lexical_scanner_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_in        (in_char_in),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_code    (out_token_code),
    .out_token_length  (out_token_length),
    .out_text_low      (out_text_low),
    .out_text_high     (out_text_high),
    .out_text_overflow (out_text_overflow),
    .out_last_of_run   (out_last_of_run)
  );

  // Run watchdog: a hung handshake or a missing token ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("FAIL keyword_lexical_scanner_unit");
      $finish;
    end
  end

  // Result side. Sample before this edge's updates land, then pick the next ready.
  // A hold request from the stimulus parks ready low for a long stretch so the
  // result queue fills and the scanner has to push back on its input.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      chars.match_token(out_token_code, out_token_length, out_text_low, out_text_high,
                        out_text_overflow, out_last_of_run);
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one character request and hold it until the scanner takes it.
  // An idle gap, if rolled, drops valid first; valid otherwise stays up across requests.
  task automatic send_char(input logic [7:0] c, input logic eoi);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char_in      <= c;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars.take_char(c, eoi);
    items_sent++;
  endtask

  // Stop offering and wait until every owed token has come back.
  task automatic drain_tokens();
    in_valid <= 1'b0;
    while (chars.due_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'h41 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h20 : 8'h00);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  // Build one well-formed token (or a burst of noise) and send it, usually
  // followed by a separator; a flush rides on the last character now and then.
  task automatic send_word();
    logic [7:0] word [$];
    logic [7:0] c;
    string      kw;
    int         pick;
    int         len;
    bit         long_one;
    bit         eoi_end;
    pick     = $urandom_range(99);
    long_one = ($urandom_range(9) == 0);
    eoi_end  = ($urandom_range(5) == 0);
    if (pick < 10) begin
      // noise: any byte, any flush
      send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end else if (pick < 35) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0:       kw = "IF";
          1:       kw = "ELSE";
          2:       kw = "ENDIF";
          default: kw = "END";
        endcase
        for (int i = 0; i < kw.len(); i++)
          word.push_back(kw[i] | ($urandom_range(1) ? 8'h20 : 8'h00));
        // sometimes stretch a keyword so it no longer matches
        if ($urandom_range(4) == 0) word.push_back(rand_letter());
      end else begin
        len = long_one ? $urandom_range(14, 20) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          word.push_back((i == 0 || $urandom_range(2) != 0) ? rand_letter() : rand_digit());
      end
    end else if (pick < 55) begin
      len = long_one ? $urandom_range(14, 18) : $urandom_range(1, 5);
      for (int i = 0; i < len; i++) word.push_back(rand_digit());
    end else if (pick < 75) begin
      len = long_one ? $urandom_range(14, 18) : $urandom_range(1, 3);
      for (int i = 0; i < len; i++) word.push_back(OP_CHARS[$urandom_range(7)]);
    end else if (pick < 85) begin
      do c = 8'($urandom_range(255));
      while (chars.letter_ch(c) || chars.digit_ch(c) || chars.oper_ch(c) || chars.blank_ch(c));
      word.push_back(c);
    end else begin
      word.push_back(rand_blank());
    end
    for (int i = 0; i < word.size(); i++)
      send_char(word[i], eoi_end && (i == word.size() - 1));
    // adjacent tokens with no separator exercise the class-change boundaries
    if ($urandom_range(3) != 0) send_char(rand_blank(), 1'b0);
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_word();
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_char_in      <= 8'h00;
    in_end_of_input <= 1'b0;
    out_ready       <= 1'b0;
    hold_left       = 0;
    hold_req        = 1'b0;
    cycles          = 0;
    items_sent      = 0;
    send_idle_pct   = 27;
    recv_idle_pct   = 64;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opener: keywords in mixed case, numbers, operator runs,
    // stray and control bytes, empty flushes.
    send_char("i", 1'b0);                 // IF, flushed by end of input
    send_char("F", 1'b1);
    send_char("e", 1'b0);                 // ELSE, ended by a space
    send_char("L", 1'b0);
    send_char("s", 1'b0);
    send_char("E", 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char("E", 1'b0);                 // END, then a carriage return: two tokens at once
    send_char("n", 1'b0);
    send_char("d", 1'b0);
    send_char(8'h0D, 1'b0);
    send_char("9", 1'b0);                 // number ended by an operator start
    send_char("0", 1'b0);
    send_char("=", 1'b0);
    send_char(":", 1'b1);                 // two-long operator run gets the catch-all code
    send_char("<", 1'b1);                 // single operator keeps its own code
    send_char(8'h00, 1'b1);               // stray byte, flush finds nothing left
    send_char(8'hFF, 1'b0);
    send_char(CH_TAB, 1'b1);              // flush with nothing pending
    send_char("z", 1'b0);
    send_char("5", 1'b1);
    send_char("/", 1'b0);                 // pending operator, then a high stray byte
    send_char(8'h80, 1'b1);
    send_char(CH_NL, 1'b0);
    drain_tokens();

    // Phase one: sender idles lightly, receiver often.
    run_random(PHASE_ITEMS / 2);
    hold_req <= 1'b1;
    run_random(PHASE_ITEMS / 2);
    drain_tokens();

    // Phase two: the other way round.
    send_idle_pct = 64;
    recv_idle_pct = 27;
    run_random(PHASE_ITEMS);
    drain_tokens();

    // Phase three: full rate both ways, with a long receiver hold while requests keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    run_random(PHASE_ITEMS);
    drain_tokens();

    repeat (8) @(posedge clk);
    if (chars.mismatches == 0) begin
      $display("PASS keyword_lexical_scanner_unit");
    end else begin
      $display("FAIL keyword_lexical_scanner_unit");
    end
    $finish;
  end

endmodule
